### src/luma_quarter_sample_interpolator_assert.svh
// Assertion macros for the luma quarter-sample interpolator.
`ifndef LUMA_QUARTER_SAMPLE_INTERPOLATOR_ASSERT_SVH
`define LUMA_QUARTER_SAMPLE_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define LQSI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lqsi: same-cycle check failed");
// Next-cycle implication.
`define LQSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lqsi: next-cycle check failed");
`else
`define LQSI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LQSI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/lqsi_pkg.sv
// Types, constants and filter arithmetic for the luma quarter-sample interpolator.
package lqsi_pkg;

   localparam int PEL_W      = 8;
   localparam int WIN_TAPS   = 6;
   localparam int HIST_ROWS  = 5;
   localparam int PAD        = 5;
   localparam int HSUM_W     = 15;
   localparam int JSUM_W     = 21;
   localparam int TAP_OUTER  = 5;
   localparam int TAP_INNER  = 20;
   localparam int HALF_ROUND = 16;
   localparam int HALF_SHIFT = 5;
   localparam int CTR_ROUND  = 512;
   localparam int CTR_SHIFT  = 10;
   localparam int PEL_MAX    = 255;

   typedef logic [PEL_W-1:0] lqsi_pel_type;
   // window indexed [column][row], column 0 and row 0 oldest
   typedef logic [WIN_TAPS-1:0][WIN_TAPS-1:0][PEL_W-1:0] lqsi_win_type;
   typedef logic signed [HSUM_W-1:0] lqsi_hsum_type;
   typedef logic signed [JSUM_W-1:0] lqsi_jsum_type;

   // quarter-sample positions, named as in the standard
   typedef enum logic [3:0] {
      PH_FULL = 4'd0,  PH_A = 4'd1,  PH_B = 4'd2,  PH_C = 4'd3,
      PH_D    = 4'd4,  PH_E = 4'd5,  PH_F = 4'd6,  PH_G = 4'd7,
      PH_H    = 4'd8,  PH_I = 4'd9,  PH_J = 4'd10, PH_K = 4'd11,
      PH_N    = 4'd12, PH_P = 4'd13, PH_Q = 4'd14, PH_R = 4'd15
   } lqsi_phase_type;

   typedef struct packed {
      logic           go;
      logic           last;
      lqsi_phase_type phase;
   } lqsi_tag_type;

   // six-tap filter over raw samples
   function automatic lqsi_hsum_type tap6_pel(input lqsi_pel_type a, input lqsi_pel_type b,
                                              input lqsi_pel_type c, input lqsi_pel_type d,
                                              input lqsi_pel_type e, input lqsi_pel_type f);
      lqsi_hsum_type xa, xb, xc, xd, xe, xf;
      xa = lqsi_hsum_type'({{(HSUM_W-PEL_W){1'b0}}, a});
      xb = lqsi_hsum_type'({{(HSUM_W-PEL_W){1'b0}}, b});
      xc = lqsi_hsum_type'({{(HSUM_W-PEL_W){1'b0}}, c});
      xd = lqsi_hsum_type'({{(HSUM_W-PEL_W){1'b0}}, d});
      xe = lqsi_hsum_type'({{(HSUM_W-PEL_W){1'b0}}, e});
      xf = lqsi_hsum_type'({{(HSUM_W-PEL_W){1'b0}}, f});
      return lqsi_hsum_type'(xa + xf - TAP_OUTER * (xb + xe) + TAP_INNER * (xc + xd));
   endfunction

   // six-tap filter over unrounded intermediates
   function automatic lqsi_jsum_type tap6_sum(input lqsi_hsum_type a, input lqsi_hsum_type b,
                                              input lqsi_hsum_type c, input lqsi_hsum_type d,
                                              input lqsi_hsum_type e, input lqsi_hsum_type f);
      return lqsi_jsum_type'(a + f - TAP_OUTER * (b + e) + TAP_INNER * (c + d));
   endfunction

   // half sample: round, shift, clip
   function automatic lqsi_pel_type round_half(input lqsi_hsum_type t);
      logic signed [HSUM_W:0] s;
      logic signed [HSUM_W:0] q;
      s = (HSUM_W+1)'(t) + (HSUM_W+1)'(HALF_ROUND);
      q = s >>> HALF_SHIFT;
      if (s < 0) begin
         return '0;
      end else if (q > PEL_MAX) begin
         return PEL_W'(PEL_MAX);
      end
      return q[PEL_W-1:0];
   endfunction

   // centre sample: round, shift, clip
   function automatic lqsi_pel_type round_ctr(input lqsi_jsum_type t);
      logic signed [JSUM_W:0] s;
      logic signed [JSUM_W:0] q;
      s = (JSUM_W+1)'(t) + (JSUM_W+1)'(CTR_ROUND);
      q = s >>> CTR_SHIFT;
      if (s < 0) begin
         return '0;
      end else if (q > PEL_MAX) begin
         return PEL_W'(PEL_MAX);
      end
      return q[PEL_W-1:0];
   endfunction

   // average with upward rounding
   function automatic lqsi_pel_type avg2(input lqsi_pel_type p, input lqsi_pel_type q);
      logic [PEL_W:0] s;
      s = {1'b0, p} + {1'b0, q} + (PEL_W+1)'(1);
      return s[PEL_W:1];
   endfunction

endpackage

### src/lqsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lqsi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lqsi_filter.sv
// Three-stage six-tap filter, rounding and quarter-sample selection.
module lqsi_filter import lqsi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  lqsi_win_type win,
   input  lqsi_tag_type tag,
   output logic         rsp_valid,
   output lqsi_pel_type rsp_predicted,
   output logic         rsp_last_of_block
);

   lqsi_tag_type  a_tag_ff, b_tag_ff;
   lqsi_hsum_type a_hsum_ff [WIN_TAPS];
   lqsi_hsum_type a_v0_ff, a_v1_ff;
   lqsi_pel_type  a_g_ff, a_right_ff, a_below_ff;
   lqsi_jsum_type b_jsum_ff;
   lqsi_pel_type  b_b0_ff, b_b1_ff, b_v0_ff, b_v1_ff, b_g_ff, b_right_ff, b_below_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   lqsi_pel_type  rsp_pel_ff;
   lqsi_pel_type  j_pel, pel_in;

   // tags carry the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff     <= '0;
         b_tag_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_tag_ff     <= tag;
         b_tag_ff     <= a_tag_ff;
         rsp_valid_ff <= b_tag_ff.go;
      end
   end

   // stage A: row and column taps
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < WIN_TAPS; k++) begin
            a_hsum_ff[k] <= tap6_pel(win[0][k], win[1][k], win[2][k],
                                     win[3][k], win[4][k], win[5][k]);
         end
         a_v0_ff    <= tap6_pel(win[2][0], win[2][1], win[2][2], win[2][3], win[2][4], win[2][5]);
         a_v1_ff    <= tap6_pel(win[3][0], win[3][1], win[3][2], win[3][3], win[3][4], win[3][5]);
         a_g_ff     <= win[2][2];
         a_right_ff <= win[3][2];
         a_below_ff <= win[2][3];
      end
   end

   // stage B: centre tap, half-sample rounding
   always_ff @(posedge clock) begin
      if (advance) begin
         b_jsum_ff  <= tap6_sum(a_hsum_ff[0], a_hsum_ff[1], a_hsum_ff[2],
                                a_hsum_ff[3], a_hsum_ff[4], a_hsum_ff[5]);
         b_b0_ff    <= round_half(a_hsum_ff[2]);
         b_b1_ff    <= round_half(a_hsum_ff[3]);
         b_v0_ff    <= round_half(a_v0_ff);
         b_v1_ff    <= round_half(a_v1_ff);
         b_g_ff     <= a_g_ff;
         b_right_ff <= a_right_ff;
         b_below_ff <= a_below_ff;
      end
   end

   // stage C: centre rounding and position select
   always_comb begin
      j_pel = round_ctr(b_jsum_ff);
      unique case (b_tag_ff.phase)
         PH_FULL: pel_in = b_g_ff;
         PH_A:    pel_in = avg2(b_g_ff, b_b0_ff);
         PH_B:    pel_in = b_b0_ff;
         PH_C:    pel_in = avg2(b_right_ff, b_b0_ff);
         PH_D:    pel_in = avg2(b_g_ff, b_v0_ff);
         PH_E:    pel_in = avg2(b_b0_ff, b_v0_ff);
         PH_F:    pel_in = avg2(b_b0_ff, j_pel);
         PH_G:    pel_in = avg2(b_b0_ff, b_v1_ff);
         PH_H:    pel_in = b_v0_ff;
         PH_I:    pel_in = avg2(b_v0_ff, j_pel);
         PH_J:    pel_in = j_pel;
         PH_K:    pel_in = avg2(b_v1_ff, j_pel);
         PH_N:    pel_in = avg2(b_below_ff, b_v0_ff);
         PH_P:    pel_in = avg2(b_v0_ff, b_b1_ff);
         PH_Q:    pel_in = avg2(j_pel, b_b1_ff);
         PH_R:    pel_in = avg2(b_v1_ff, b_b1_ff);
      endcase
   end

   // output word register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pel_ff  <= pel_in;
         rsp_last_ff <= b_tag_ff.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_predicted     = rsp_pel_ff;
   assign rsp_last_of_block = rsp_last_ff;

endmodule

### src/luma_quarter_sample_interpolator.sv
// Top level of the luma quarter-sample interpolator: window control, line RAM, window.
//
//  channel | direction | words
//  req_    | in        | sample, frac_x, frac_y, block_width, block_height, first_of_block
//  rsp_    | out       | predicted, last_of_block
//
// One window sample is taken every cycle unless rsp_ stalls; the line RAM is read at the accepted
// column and written back from stage 1, so one word per cycle is sustained while rsp_ does not stall.
// A word reaches rsp_ via stage 1, the window, filter stages A and B and the output register.
// Reset clears position, block state and valid bits; the line RAM needs no clearing.
// A stalled rsp_ word holds the whole pipeline, and req_ready falls with it.
`include "luma_quarter_sample_interpolator_assert.svh"
module luma_quarter_sample_interpolator import lqsi_pkg::*; #(
   parameter int MAX_BLOCK_SIZE = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_sample,
   input  logic [1:0] req_frac_x,
   input  logic [1:0] req_frac_y,
   input  logic [4:0] req_block_width,
   input  logic [4:0] req_block_height,
   input  logic       req_first_of_block,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_predicted,
   output logic       rsp_last_of_block
);

   localparam int WIN_W = MAX_BLOCK_SIZE + PAD;
   localparam int PW_W  = $clog2(WIN_W + 1);
   localparam int AW    = $clog2(WIN_W);
   localparam int COL_W = HIST_ROWS * PEL_W;

   function automatic logic [PW_W-1:0] clamp_size(input logic [4:0] s);
      if (s == 5'd0) begin
         return PW_W'(1);
      end else if (int'(s) > MAX_BLOCK_SIZE) begin
         return PW_W'(MAX_BLOCK_SIZE);
      end
      return PW_W'(s);
   endfunction

   logic            advance, accept;
   logic            active_ff, active_in;
   logic [PW_W-1:0] col_ff, col_in, row_ff, row_in, pw_ff, pw_in, ph_ff, ph_in;
   lqsi_phase_type  phase_ff, phase_in;
   logic [PW_W-1:0] s0_col, s0_row, s0_col_inc, s0_row_inc;
   logic            s0_in_block, s0_produce, s0_last;
   logic            s1_valid_ff;
   lqsi_pel_type    s1_sample_ff;
   logic [AW-1:0]   s1_addr_ff;
   lqsi_tag_type    s1_tag_ff, s2_tag_ff;
   lqsi_win_type    win_ff;
   logic [COL_W-1:0] ram_rdata, ram_wdata;
   logic            flt_valid;
   lqsi_pel_type    flt_pel;
   logic            flt_last;

   assign advance   = !flt_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // window position of the offered word
   always_comb begin
      s0_in_block = req_first_of_block || active_ff;
      pw_in       = req_first_of_block ? clamp_size(req_block_width) + PW_W'(PAD) : pw_ff;
      ph_in       = req_first_of_block ? clamp_size(req_block_height) + PW_W'(PAD) : ph_ff;
      phase_in    = req_first_of_block ? lqsi_phase_type'({req_frac_y, req_frac_x}) : phase_ff;
      s0_col      = req_first_of_block ? '0 : col_ff;
      s0_row      = req_first_of_block ? '0 : row_ff;
      s0_col_inc  = s0_col + PW_W'(1);
      s0_row_inc  = s0_row + PW_W'(1);
      s0_produce  = (s0_col >= PW_W'(PAD)) && (s0_row >= PW_W'(PAD));
      s0_last     = (s0_col == pw_in - PW_W'(1)) && (s0_row == ph_in - PW_W'(1));
   end

   // next position
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      active_in = active_ff;
      if (accept && s0_in_block) begin
         if (s0_col_inc == pw_in) begin
            col_in    = '0;
            row_in    = s0_row_inc;
            active_in = (s0_row_inc != ph_in);
         end else begin
            col_in    = s0_col_inc;
            row_in    = s0_row;
            active_in = 1'b1;
         end
      end
   end

   // block control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         pw_ff     <= '0;
         ph_ff     <= '0;
         phase_ff  <= PH_FULL;
      end else begin
         active_ff <= active_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         if (accept && req_first_of_block) begin
            pw_ff    <= pw_in;
            ph_ff    <= ph_in;
            phase_ff <= phase_in;
         end
      end
   end

   // stage 1: waiting on line RAM read; stage 2 tag
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_tag_ff   <= '0;
         s2_tag_ff   <= '0;
      end else if (advance) begin
         s1_valid_ff    <= accept && s0_in_block;
         s1_tag_ff.go   <= s0_produce;
         s1_tag_ff.last <= s0_last;
         s1_tag_ff.phase <= phase_in;
         s2_tag_ff.go   <= s1_valid_ff && s1_tag_ff.go;
         s2_tag_ff.last <= s1_tag_ff.last;
         s2_tag_ff.phase <= s1_tag_ff.phase;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sample_ff <= req_sample;
         s1_addr_ff   <= s0_col[AW-1:0];
      end
   end

   // column entry: oldest row drops out, new sample goes on top
   assign ram_wdata = {s1_sample_ff, ram_rdata[COL_W-1:PEL_W]};

   lqsi_ram #(
      .WIDTH (COL_W),
      .DEPTH (WIN_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (advance && s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (s0_col[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // 6x6 window shifts one column per window sample
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         for (int c = 0; c < WIN_TAPS - 1; c++) begin
            win_ff[c] <= win_ff[c+1];
         end
         for (int r = 0; r < HIST_ROWS; r++) begin
            win_ff[WIN_TAPS-1][r] <= ram_rdata[r*PEL_W +: PEL_W];
         end
         win_ff[WIN_TAPS-1][WIN_TAPS-1] <= s1_sample_ff;
      end
   end

   lqsi_filter u_filter (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .win               (win_ff),
      .tag               (s2_tag_ff),
      .rsp_valid         (flt_valid),
      .rsp_predicted     (flt_pel),
      .rsp_last_of_block (flt_last)
   );

   assign rsp_valid         = flt_valid;
   assign rsp_predicted     = flt_pel;
   assign rsp_last_of_block = flt_last;

   // checks
   `LQSI_ASSERT_NEXT(a_last_ends_block, clock, reset, accept && s0_in_block && s0_last, !active_ff)
   `LQSI_ASSERT_NEXT(a_first_opens_block, clock, reset, accept && req_first_of_block, active_ff && (row_ff == '0))
   `LQSI_ASSERT_IMPL(a_col_in_window, clock, reset, active_ff, col_ff < pw_ff)

endmodule
